### rtl/pht_pkg.sv
// Shared constants, codes and types for the pheromone table block.
// No dependencies; imported by the top level and by pht_engine.
`default_nettype none

package pht_pkg;

  localparam int MAX_MACHINES = 4;
  localparam int MAX_TASKS    = 16;

  localparam int M_W    = $clog2(MAX_MACHINES);
  localparam int T_W    = $clog2(MAX_TASKS);
  localparam int ADDR_W = M_W + 2 * T_W;
  localparam int DEPTH  = MAX_MACHINES * MAX_TASKS * MAX_TASKS;
  localparam int MC_W   = $clog2(MAX_MACHINES + 1);
  localparam int TC_W   = $clog2(MAX_TASKS + 1);

  localparam int ENTRY_W = 32;
  localparam int SUM_W   = 36;
  localparam int RATE_W  = 16;
  localparam int KEEP_W  = RATE_W + 1;
  localparam int MASK_W  = 16;
  localparam int REQ_W   = 2;

  localparam logic [ENTRY_W-1:0] PH_INIT       = 32'd655360;
  localparam logic [RATE_W-1:0]  PH_RATE_RESET = 16'd19661;

  typedef enum logic [REQ_W-1:0] {
    REQ_EVAP    = 2'd0,
    REQ_DEPOSIT = 2'd1,
    REQ_TOTAL   = 2'd2,
    REQ_READ    = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    CFG_MACHINES = 2'd0,
    CFG_TASKS    = 2'd1,
    CFG_RATE     = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAP,
    ST_EVAP_DRAIN,
    ST_TOT,
    ST_TOT_DRAIN,
    ST_DEP_WR,
    ST_RD_WAIT,
    ST_FINISH
  } pht_state_t;

  // effective (clamped) configuration
  typedef struct packed {
    logic [MC_W-1:0]   machines;
    logic [TC_W-1:0]   tasks;
    logic [RATE_W-1:0] rate;
  } pht_cfg_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] deposit_amount;
    logic [MASK_W-1:0]  unselected_mask;
    logic [T_W-1:0]     col_task;
    logic [T_W-1:0]     row_task;
    logic [M_W-1:0]     machine;
    req_type_t          req_type;
  } pht_req_t;

  typedef struct packed {
    logic              status;
    logic [SUM_W-1:0]  value;
  } pht_res_t;

endpackage

`default_nettype wire

### rtl/ant_colony_pheromone_table_top.sv
// Top level of the pheromone table: config registers, stream ports, output
// register. Depends on pht_pkg, pht_engine and pht_ram.
//
//  channel  dir  handshake            payload
//  in_      in   in_tvalid/in_tready  in_tdata: request item
//  out_     out  out_tvalid/out_tready out_tdata: value and status
//  cfg_     in   cfg_we               cfg_index, cfg_data
//
// After reset the table is cleared to 10.0, one entry a cycle, with in_tready
// low until all 1024 entries are written. Read and deposit each make one RAM
// read; an index error skips the RAM. Total and evaporate read their entries
// one at a time through the one RAM read port. The output register holds a
// result while the next item is accepted; a stalled output only holds the
// engine once its next result is ready.
`default_nettype none

module ant_colony_pheromone_table_top import pht_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // req_type[1:0], machine[3:2], row_task[7:4], col_task[11:8],
  // unselected_mask[27:12], deposit_amount[59:28], zero pad[63:60]
  input  wire logic [63:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // value[35:0], status[36], zero pad[39:37]
  output logic [39:0]      out_tdata,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int IN_USED_W = $bits(pht_req_t);
  localparam int RES_W     = $bits(pht_res_t);

  logic [2:0]        machines_in_use_r;
  logic [4:0]        tasks_in_use_r;
  logic [RATE_W-1:0] evaporation_rate_r;

  pht_cfg_t cfg;
  pht_req_t req;
  pht_res_t res;
  pht_res_t out_data_r, out_data_nxt;
  logic     out_tvalid_r, out_tvalid_nxt;
  logic     res_valid, res_take;

  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      machines_in_use_r  <= 3'd4;
      tasks_in_use_r     <= 5'd16;
      evaporation_rate_r <= PH_RATE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MACHINES: machines_in_use_r  <= cfg_data[2:0];
        CFG_TASKS:    tasks_in_use_r     <= cfg_data[4:0];
        CFG_RATE:     evaporation_rate_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.machines = (int'(machines_in_use_r) >= MAX_MACHINES) ?
                   MC_W'(MAX_MACHINES) : MC_W'(machines_in_use_r);
    cfg.tasks    = (int'(tasks_in_use_r) >= MAX_TASKS) ?
                   TC_W'(MAX_TASKS) : TC_W'(tasks_in_use_r);
    cfg.rate     = evaporation_rate_r;
  end

  assign req = pht_req_t'(in_tdata[IN_USED_W-1:0]);

  pht_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_take),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  pht_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign res_take = res_valid && (!out_tvalid_r || out_tready);

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_data_nxt   = out_data_r;
    if (res_take) begin
      out_tvalid_nxt = 1'b1;
      out_data_nxt   = res;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {(40 - RES_W)'(0), out_data_r};

  // table is being cleared right after reset
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> !in_tready)
    else $error("item accepted during clearing pass");

  // no write-back may still be in flight when a new item enters
  a_no_write_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> !ram_we)
    else $error("RAM write overlaps item acceptance");

  a_finish_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !in_tready)
    else $error("input accepted while a result is pending");

  a_error_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[SUM_W]) |-> (out_tdata[SUM_W-1:0] == '0))
    else $error("error result carries a non-zero value");

endmodule

`default_nettype wire

### rtl/pht_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module pht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/pht_engine.sv
// Request sequencer and datapath: clearing pass, evaporation sweep, deposit,
// masked row total and entry read around the table RAM. Depends on pht_pkg.
`default_nettype none

module pht_engine import pht_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire pht_cfg_t           cfg,
  input  wire logic               req_valid,
  output logic                    req_ready,
  input  wire pht_req_t           req,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output pht_res_t                res,
  output logic                    ram_we,
  output logic [ADDR_W-1:0]       ram_waddr,
  output logic [ENTRY_W-1:0]      ram_wdata,
  output logic                    ram_re,
  output logic [ADDR_W-1:0]       ram_raddr,
  input  wire logic [ENTRY_W-1:0] ram_rdata
);

  pht_state_t         state_r, state_nxt;
  logic [ADDR_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  req_type_t          req_type_r, req_type_nxt;
  logic [M_W-1:0]     m_r, m_nxt;
  logic [T_W-1:0]     row_r, row_nxt;
  logic [MASK_W-1:0]  mask_r, mask_nxt;
  logic [ENTRY_W-1:0] inc_r, inc_nxt;
  logic [M_W-1:0]     a_r, a_nxt;
  logic [T_W-1:0]     b_r, b_nxt;
  logic [T_W-1:0]     d_r, d_nxt;
  logic [SUM_W-1:0]   acc_r, acc_nxt;
  pht_res_t           res_r, res_nxt;

  // read pipeline: s1 = RAM data valid, s2 = scaled entry waiting for write
  logic               s1_vld_r, s1_vld_nxt;
  logic               s1_use_r, s1_use_nxt;
  logic [ADDR_W-1:0]  s1_addr_r, s1_addr_nxt;
  logic               s2_vld_r, s2_vld_nxt;
  logic [ADDR_W-1:0]  s2_addr_r, s2_addr_nxt;
  logic [ENTRY_W-1:0] s2_data_r, s2_data_nxt;

  logic                        rd_use;
  logic                        m_bad, r_bad, c_bad, idx_err, evap_none;
  logic                        a_last, b_last, d_last;
  logic [ENTRY_W+RATE_W-1:0]   inc_prod;
  logic [KEEP_W-1:0]           keep;
  logic [ENTRY_W+KEEP_W-1:0]   evap_prod;
  logic [ENTRY_W:0]            dep_sum;
  logic [ENTRY_W-1:0]          dep_sat;
  logic [SUM_W:0]              acc_sum;

  assign m_bad   = MC_W'(req.machine) >= cfg.machines;
  assign r_bad   = TC_W'(req.row_task) >= cfg.tasks;
  assign c_bad   = TC_W'(req.col_task) >= cfg.tasks;
  assign idx_err = m_bad || r_bad || (c_bad && (req.req_type != REQ_TOTAL));
  assign evap_none = (cfg.machines == '0) || (cfg.tasks == '0);

  assign a_last = (MC_W'(a_r) + MC_W'(1)) == cfg.machines;
  assign b_last = (TC_W'(b_r) + TC_W'(1)) == cfg.tasks;
  assign d_last = (TC_W'(d_r) + TC_W'(1)) == cfg.tasks;

  assign inc_prod  = (ENTRY_W+RATE_W)'(req.deposit_amount) * (ENTRY_W+RATE_W)'(cfg.rate);
  assign keep      = KEEP_W'(1 << RATE_W) - KEEP_W'(cfg.rate);
  assign evap_prod = (ENTRY_W+KEEP_W)'(ram_rdata) * (ENTRY_W+KEEP_W)'(keep);
  assign dep_sum   = {1'b0, ram_rdata} + {1'b0, inc_r};
  assign dep_sat   = dep_sum[ENTRY_W] ? '1 : dep_sum[ENTRY_W-1:0];
  assign acc_sum   = {1'b0, acc_r} + (SUM_W+1)'(ram_rdata);

  assign req_ready = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_FINISH);
  assign res       = res_r;

  always_comb begin
    state_nxt    = state_r;
    clr_cnt_nxt  = clr_cnt_r;
    req_type_nxt = req_type_r;
    m_nxt        = m_r;
    row_nxt      = row_r;
    mask_nxt     = mask_r;
    inc_nxt      = inc_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    d_nxt        = d_r;
    res_nxt      = res_r;
    ram_re       = 1'b0;
    ram_raddr    = {req.machine, req.row_task, req.col_task};
    rd_use       = 1'b0;

    acc_nxt = acc_r;
    if (s1_vld_r && s1_use_r) begin
      acc_nxt = acc_sum[SUM_W] ? '1 : acc_sum[SUM_W-1:0];
    end

    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
        if (clr_cnt_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid) begin
          req_type_nxt = req.req_type;
          m_nxt        = req.machine;
          row_nxt      = req.row_task;
          mask_nxt     = req.unselected_mask;
          inc_nxt      = inc_prod[RATE_W +: ENTRY_W];
          a_nxt        = '0;
          b_nxt        = '0;
          d_nxt        = '0;
          acc_nxt      = '0;
          res_nxt      = '0;
          case (req.req_type)
            REQ_EVAP: begin
              state_nxt = evap_none ? ST_FINISH : ST_EVAP;
            end
            REQ_DEPOSIT: begin
              if (idx_err) begin
                res_nxt.status = 1'b1;
                state_nxt      = ST_FINISH;
              end else begin
                ram_re    = 1'b1;
                state_nxt = ST_DEP_WR;
              end
            end
            REQ_TOTAL: begin
              if (idx_err) begin
                res_nxt.status = 1'b1;
                state_nxt      = ST_FINISH;
              end else begin
                state_nxt = ST_TOT;
              end
            end
            REQ_READ: begin
              if (idx_err) begin
                res_nxt.status = 1'b1;
                state_nxt      = ST_FINISH;
              end else begin
                ram_re    = 1'b1;
                state_nxt = ST_RD_WAIT;
              end
            end
            default: begin
              state_nxt = ST_FINISH;
            end
          endcase
        end
      end
      ST_EVAP: begin
        ram_re    = 1'b1;
        ram_raddr = {a_r, b_r, d_r};
        if (d_last) begin
          d_nxt = '0;
          if (b_last) begin
            b_nxt = '0;
            if (a_last) begin
              state_nxt = ST_EVAP_DRAIN;
            end else begin
              a_nxt = a_r + M_W'(1);
            end
          end else begin
            b_nxt = b_r + T_W'(1);
          end
        end else begin
          d_nxt = d_r + T_W'(1);
        end
      end
      ST_EVAP_DRAIN: begin
        // wait until the last scaled entries are written back
        if (!s1_vld_r && !s2_vld_r) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_TOT: begin
        ram_re    = 1'b1;
        ram_raddr = {m_r, row_r, d_r};
        rd_use    = mask_r[d_r];
        if (d_last) begin
          state_nxt = ST_TOT_DRAIN;
        end else begin
          d_nxt = d_r + T_W'(1);
        end
      end
      ST_TOT_DRAIN: begin
        if (!s1_vld_r) begin
          res_nxt.value = acc_r;
          state_nxt     = ST_FINISH;
        end
      end
      ST_DEP_WR: begin
        state_nxt = ST_FINISH;
      end
      ST_RD_WAIT: begin
        res_nxt.value = SUM_W'(ram_rdata);
        state_nxt     = ST_FINISH;
      end
      ST_FINISH: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s1_vld_nxt  = ram_re;
    s1_use_nxt  = rd_use;
    s1_addr_nxt = ram_raddr;
    s2_vld_nxt  = s1_vld_r && (req_type_r == REQ_EVAP);
    s2_addr_nxt = s1_addr_r;
    s2_data_nxt = evap_prod[RATE_W +: ENTRY_W];
  end

  // single write port: clearing pass, evaporation write-back, deposit
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = s1_addr_r;
    ram_wdata = dep_sat;
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = PH_INIT;
    end else if (s2_vld_r) begin
      ram_we    = 1'b1;
      ram_waddr = s2_addr_r;
      ram_wdata = s2_data_r;
    end else if (state_r == ST_DEP_WR) begin
      ram_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      s1_vld_r  <= s1_vld_nxt;
      s2_vld_r  <= s2_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_type_r <= req_type_nxt;
    m_r        <= m_nxt;
    row_r      <= row_nxt;
    mask_r     <= mask_nxt;
    inc_r      <= inc_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    d_r        <= d_nxt;
    acc_r      <= acc_nxt;
    res_r      <= res_nxt;
    s1_use_r   <= s1_use_nxt;
    s1_addr_r  <= s1_addr_nxt;
    s2_addr_r  <= s2_addr_nxt;
    s2_data_r  <= s2_data_nxt;
  end

endmodule

`default_nettype wire
